>>> hw/rtl/u16u8_pkg.sv
package u16u8_pkg;

  localparam int unsigned UnitW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CpW       = 21;
  localparam int unsigned LenW      = 2;
  localparam int unsigned QueueDepth = 2;

  localparam logic [UnitW-1:0] SurrLo   = 16'hD800;
  localparam logic [UnitW-1:0] SurrHi   = 16'hE000;
  localparam logic [CpW-1:0]   Lim1Byte = 21'h00080;
  localparam logic [CpW-1:0]   Lim2Byte = 21'h00800;
  localparam logic [CpW-1:0]   Lim3Byte = 21'h10000;
  localparam logic [ByteW-1:0] Lead2    = 8'hC0;
  localparam logic [ByteW-1:0] Lead3    = 8'hE0;
  localparam logic [ByteW-1:0] Lead4    = 8'hF0;
  localparam logic [ByteW-1:0] ContMark = 8'h80;

  // Index of the final byte of a sequence (byte count minus one)
  localparam logic [LenW-1:0] Len1 = 2'd0;
  localparam logic [LenW-1:0] Len2 = 2'd1;
  localparam logic [LenW-1:0] Len3 = 2'd2;
  localparam logic [LenW-1:0] Len4 = 2'd3;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             last_unit;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] utf8_byte;
    logic             run_end;
  } out_item_t;

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] last_idx;
  } cp_item_t;

  function automatic logic [LenW-1:0] cp_last_idx(input logic [CpW-1:0] cp);
    logic [LenW-1:0] r;
    if (cp < Lim1Byte) begin
      r = Len1;
    end else if (cp < Lim2Byte) begin
      r = Len2;
    end else if (cp < Lim3Byte) begin
      r = Len3;
    end else begin
      r = Len4;
    end
    return r;
  endfunction

  function automatic logic [ByteW-1:0] utf8_byte_at(input logic [CpW-1:0]  cp,
                                                    input logic [LenW-1:0] last_idx,
                                                    input logic [LenW-1:0] idx);
    logic [LenW-1:0]  pos;
    logic [5:0]       six;
    logic [ByteW-1:0] r;
    pos = last_idx - idx;
    case (pos)
      2'd0:    six = cp[5:0];
      2'd1:    six = cp[11:6];
      2'd2:    six = cp[17:12];
      default: six = {3'b000, cp[20:18]};
    endcase
    if (idx == '0) begin
      case (last_idx)
        Len1:    r = cp[7:0];
        Len2:    r = Lead2 | {3'b000, cp[10:6]};
        Len3:    r = Lead3 | {4'b0000, cp[15:12]};
        default: r = Lead4 | {5'b00000, cp[20:18]};
      endcase
    end else begin
      r = ContMark | {2'b00, six};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/u16u8_front.sv
module u16u8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  u16u8_pkg::in_item_t item_i,
  output logic                push_o,
  output u16u8_pkg::cp_item_t cp_item_o
);

  logic       held_valid_q, held_valid_d;
  logic [9:0] held_unit_q, held_unit_d;
  logic       is_surr;
  logic       hold;
  logic [4:0] plane;
  logic [u16u8_pkg::CpW-1:0] cp;

  assign is_surr = (item_i.code_unit >= u16u8_pkg::SurrLo) &&
                   (item_i.code_unit <  u16u8_pkg::SurrHi);
  assign hold    = !held_valid_q && is_surr && !item_i.last_unit;

  // Surrogate pair: plane field gets the +1 offset, low unit is not checked
  assign plane = {1'b0, held_unit_q[9:6]} + 5'd1;

  always_comb begin
    if (held_valid_q) begin
      cp = {plane, held_unit_q[5:0], item_i.code_unit[9:0]};
    end else begin
      cp = {5'd0, item_i.code_unit};
    end
    held_valid_d = held_valid_q;
    held_unit_d  = held_unit_q;
    if (accept_i) begin
      held_valid_d = hold;
      if (hold) begin
        held_unit_d = item_i.code_unit[9:0];
      end
    end
  end

  assign push_o             = accept_i && !hold;
  assign cp_item_o.cp       = cp;
  assign cp_item_o.last_idx = u16u8_pkg::cp_last_idx(cp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_unit_q  <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_unit_q  <= held_unit_d;
    end
  end

endmodule

>>> hw/rtl/u16u8_queue.sv
module u16u8_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  u16u8_pkg::cp_item_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output u16u8_pkg::cp_item_t data_o
);

  localparam int unsigned PtrW = (u16u8_pkg::QueueDepth > 1) ?
                                 $clog2(u16u8_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(u16u8_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(u16u8_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(u16u8_pkg::QueueDepth - 1);

  u16u8_pkg::cp_item_t mem_q [u16u8_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == DepthCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/u16u8_back.sv
module u16u8_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  u16u8_pkg::cp_item_t  q_data_i,
  output logic                 q_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output u16u8_pkg::out_item_t item_o
);

  u16u8_pkg::cp_item_t       cur_q;
  logic                      cur_valid_q, cur_valid_d;
  logic [u16u8_pkg::LenW-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  u16u8_pkg::out_item_t      out_q;
  logic                      emit, emit_last, cur_load;

  assign emit      = cur_valid_q && (!out_valid_q || pop_i);
  assign emit_last = emit && (idx_q == cur_q.last_idx);
  assign cur_load  = q_valid_i && (!cur_valid_q || emit_last);
  assign q_pop_o   = cur_load;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      idx_d = idx_q + 1'b1;
    end
    if (emit_last) begin
      cur_valid_d = 1'b0;
      idx_d       = '0;
    end
    if (cur_load) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_load) begin
      cur_q <= q_data_i;
    end
    if (emit) begin
      out_q.utf8_byte <= u16u8_pkg::utf8_byte_at(cur_q.cp, cur_q.last_idx, idx_q);
      out_q.run_end   <= (idx_q == cur_q.last_idx);
    end
  end

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

endmodule

>>> hw/rtl/utf16_to_utf8_encoder.sv
// Path: the item that completes a code point is written into the queue, loaded into the byte
//   sequencer and its first byte registered into the output; a held surrogate unit gives no byte.
// Throughput: one byte per cycle from the byte sequencer while the result side is popped;
//   an item gives 1 to 4 bytes (the byte count of its code point).
// Reset: asynchronous, active low; clears the held unit, the queue and the output.
module utf16_to_utf8_encoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input side: item taken when push is high and full is low
  input  logic                 push,
  output logic                 full,
  input  u16u8_pkg::in_item_t  in_item_i,
  // Result side: item taken when pop is high and empty is low
  output logic                 empty,
  input  logic                 pop,
  output u16u8_pkg::out_item_t out_item_o
);

  logic                accept;
  logic                f_push;
  u16u8_pkg::cp_item_t f_item;
  logic                q_valid, q_pop;
  u16u8_pkg::cp_item_t q_item;

  // Accept whenever the code point queue has room; a held unit simply pushes nothing
  assign accept = push && !full;

  // Front: pair surrogates, build the code point and its byte count
  u16u8_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .push_o    (f_push),
    .cp_item_o (f_item)
  );

  // Short queue between front and back so each side can stall on its own
  u16u8_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  // Back: walk one code point's bytes, one per cycle unless pop stalls, into the output register
  u16u8_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_item),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .item_o    (out_item_o)
  );

endmodule

>>> hw/rtl/u16u8_checker.sv
module u16u8_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input u16u8_pkg::out_item_t out_item_o
);

  // Pending item holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("pending item changed or vanished");

  // Bytes of one run follow without a gap, each a continuation byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_item_o.run_end) |=>
      (!empty && out_item_o.utf8_byte[7:6] == 2'b10))
    else $error("run broken after a non-final byte");

  // A multibyte lead byte never ends its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.utf8_byte[7:6] == 2'b11) |-> !out_item_o.run_end)
    else $error("lead byte marked as run end");

  // Output side comes out of reset empty
  assert property (@(posedge clk_i)
    !rst_ni |=> empty)
    else $error("result shown right after reset");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
